FILE: hdl/rrss_pkg.sv
`timescale 1ns / 1ps
package rrss_pkg;

  localparam int MAX_PROCS = 16;
  localparam int IDX_W = $clog2(MAX_PROCS);
  localparam int CNT_W = IDX_W + 1;
  localparam int TIME_W = 21;
  localparam int SUM_W = 25;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_SLICE = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [7:0]  proc_id;
    logic [15:0] arrival;
    logic [15:0] burst;
  } slice_in_t;

  typedef struct packed {
    logic              slice_valid;
    logic [7:0]        slice_proc;
    logic [TIME_W-1:0] slice_start;
    logic [TIME_W-1:0] slice_end;
    logic              proc_finished;
    logic              schedule_done;
    logic [SUM_W-1:0]  wait_sum;
    logic [SUM_W-1:0]  turnaround_sum;
  } slice_out_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_SCAN_INIT,
    OP_SCAN_STEP,
    OP_SHIFT_INIT,
    OP_SHIFT_STEP,
    OP_INSERT,
    OP_GAP,
    OP_ADMIT,
    OP_EMPTY,
    OP_POP,
    OP_REQUEUE,
    OP_TAT,
    OP_ACCUM,
    OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic is_load;
    logic load_ok;
    logic scan_more;
    logic shift_more;
    logic admit_more;
    logic fifo_empty;
    logic gap_needed;
    logic rem_zero;
    logic out_free;
  } dp_status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN,
    ST_SHIFT,
    ST_ADMIT_PRE,
    ST_CHECK,
    ST_ADMIT_POST,
    ST_END,
    ST_ACCUM,
    ST_EMIT
  } ctrl_state_t;

endpackage

FILE: hdl/round_robin_slice_scheduler.sv
`timescale 1ns / 1ps
// channel | direction | handshake       | payload
// in      | input     | in_valid/stall  | slice_in_t (mode, proc_id, arrival, burst)
// out     | output    | out_valid/stall | slice_out_t (one result per slice request)
// cfg     | input     | cfg_valid/ready | quantum, 16 bits
//
// a load stalls input while it scans to its slot and shifts the tail; an ignored load
//   stalls input too
// a slice request stalls input while it pops a process, admits arrivals one by one and
//   requeues or retires the process; an idle gap and an empty result stall input as well
// rst is synchronous; it clears counts, the ready queue, time and sums, quantum = 4
// a result waits in the output register under out_stall while input is taken
module round_robin_slice_scheduler
  import rrss_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  slice_in_t   in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output slice_out_t  out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // quantum register takes every transfer
  assign cfg_ready = 1'b1;

  // sequencer for load insertion and slice steps
  rrss_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // process tables, ready queue, time and sums
  rrss_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: hdl/rrss_ctrl.sv
`timescale 1ns / 1ps
module rrss_ctrl
  import rrss_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.op = OP_NONE;
    in_stall = (state != ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op = OP_LATCH;
          state_next = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (status.is_load) begin
          if (status.load_ok) begin
            cmd.op = OP_SCAN_INIT;
            state_next = ST_SCAN;
          end else begin
            state_next = ST_IDLE;
          end
        end else if (status.fifo_empty && status.gap_needed) begin
          cmd.op = OP_GAP;
          state_next = ST_ADMIT_PRE;
        end else begin
          state_next = ST_CHECK;
        end
      end
      ST_SCAN: begin
        if (status.scan_more) begin
          cmd.op = OP_SCAN_STEP;
        end else begin
          cmd.op = OP_SHIFT_INIT;
          state_next = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        if (status.shift_more) begin
          cmd.op = OP_SHIFT_STEP;
        end else begin
          cmd.op = OP_INSERT;
          state_next = ST_IDLE;
        end
      end
      ST_ADMIT_PRE: begin
        if (status.admit_more) begin
          cmd.op = OP_ADMIT;
        end else begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status.fifo_empty) begin
          cmd.op = OP_EMPTY;
          state_next = ST_EMIT;
        end else begin
          cmd.op = OP_POP;
          state_next = ST_ADMIT_POST;
        end
      end
      ST_ADMIT_POST: begin
        if (status.admit_more) begin
          cmd.op = OP_ADMIT;
        end else begin
          state_next = ST_END;
        end
      end
      ST_END: begin
        if (status.rem_zero) begin
          cmd.op = OP_TAT;
          state_next = ST_ACCUM;
        end else begin
          cmd.op = OP_REQUEUE;
          state_next = ST_EMIT;
        end
      end
      ST_ACCUM: begin
        cmd.op = OP_ACCUM;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.op = OP_EMIT;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: hdl/rrss_datapath.sv
`timescale 1ns / 1ps
module rrss_datapath
  import rrss_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  dp_cmd_t     cmd,
  output dp_status_t  status,
  input  slice_in_t   in_data,
  input  logic        cfg_valid,
  input  logic [15:0] cfg_data,
  output logic        out_valid,
  input  logic        out_stall,
  output slice_out_t  out_data
);

  logic [15:0] arr_tab [MAX_PROCS];
  logic [15:0] bst_tab [MAX_PROCS];
  logic [15:0] rem_tab [MAX_PROCS];
  logic [7:0]  id_tab  [MAX_PROCS];
  logic [IDX_W-1:0] fifo [MAX_PROCS];

  logic [CNT_W-1:0]  loaded, fill, nai, finished, k, pos;
  logic [IDX_W-1:0]  head, idx;
  logic [TIME_W-1:0] cur_time, limit;
  logic [SUM_W-1:0]  wait_total, tat_total, tat;
  logic [15:0]       quantum;
  slice_in_t         item;

  logic              r_valid, r_fin;
  logic [7:0]        r_proc;
  logic [TIME_W-1:0] r_start, r_end;

  logic [15:0]       q_eff, run, rem_pop, arr_nai;
  logic [TIME_W-1:0] end_pop;
  logic [IDX_W-1:0]  push_addr;
  logic              out_free;

  assign q_eff = (quantum == 16'd0) ? 16'd1 : quantum;
  assign rem_pop = rem_tab[fifo[head]];
  assign run = (rem_pop < q_eff) ? rem_pop : q_eff;
  assign end_pop = cur_time + TIME_W'(run);
  assign push_addr = IDX_W'(head + fill[IDX_W-1:0]);
  assign arr_nai = arr_tab[nai[IDX_W-1:0]];
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    status.is_load = (item.mode == MODE_LOAD);
    status.load_ok = (loaded < CNT_W'(MAX_PROCS)) && (nai == '0);
    status.scan_more = (k < loaded) && (arr_tab[k[IDX_W-1:0]] <= item.arrival);
    status.shift_more = (k > pos);
    status.admit_more = (nai < loaded) && ({5'd0, arr_nai} <= limit);
    status.fifo_empty = (fill == '0);
    status.gap_needed = (nai < loaded);
    status.rem_zero = (rem_tab[idx] == 16'd0);
    status.out_free = out_free;
  end

  // register write port, always ready
  always_ff @(posedge clk) begin
    if (rst) begin
      quantum <= 16'd4;
    end else if (cfg_valid) begin
      quantum <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      loaded <= '0;
      fill <= '0;
      nai <= '0;
      finished <= '0;
      head <= '0;
      cur_time <= '0;
      wait_total <= '0;
      tat_total <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.op == OP_EMIT) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (cmd.op)
        OP_NONE: begin
        end
        OP_LATCH: begin
          item <= in_data;
        end
        OP_SCAN_INIT: begin
          k <= '0;
        end
        OP_SCAN_STEP: begin
          k <= k + 1'b1;
        end
        OP_SHIFT_INIT: begin
          pos <= k;
          k <= loaded;
        end
        OP_SHIFT_STEP: begin
          arr_tab[k[IDX_W-1:0]] <= arr_tab[IDX_W'(k - 1'b1)];
          bst_tab[k[IDX_W-1:0]] <= bst_tab[IDX_W'(k - 1'b1)];
          rem_tab[k[IDX_W-1:0]] <= rem_tab[IDX_W'(k - 1'b1)];
          id_tab[k[IDX_W-1:0]]  <= id_tab[IDX_W'(k - 1'b1)];
          k <= k - 1'b1;
        end
        OP_INSERT: begin
          arr_tab[pos[IDX_W-1:0]] <= item.arrival;
          bst_tab[pos[IDX_W-1:0]] <= (item.burst == 16'd0) ? 16'd1 : item.burst;
          rem_tab[pos[IDX_W-1:0]] <= (item.burst == 16'd0) ? 16'd1 : item.burst;
          id_tab[pos[IDX_W-1:0]]  <= item.proc_id;
          loaded <= loaded + 1'b1;
        end
        OP_GAP: begin
          // idle gap: jump ahead to the next arrival
          if ({5'd0, arr_nai} > cur_time) begin
            cur_time <= {5'd0, arr_nai};
            limit <= {5'd0, arr_nai};
          end else begin
            limit <= cur_time;
          end
        end
        OP_ADMIT: begin
          if (fill < CNT_W'(MAX_PROCS)) begin
            fifo[push_addr] <= nai[IDX_W-1:0];
            fill <= fill + 1'b1;
          end
          nai <= nai + 1'b1;
        end
        OP_EMPTY: begin
          r_valid <= 1'b0;
          r_proc <= '0;
          r_start <= '0;
          r_end <= '0;
          r_fin <= 1'b0;
        end
        OP_POP: begin
          idx <= fifo[head];
          rem_tab[fifo[head]] <= rem_pop - run;
          head <= head + 1'b1;
          fill <= fill - 1'b1;
          limit <= end_pop;
          cur_time <= end_pop;
          r_valid <= 1'b1;
          r_proc <= id_tab[fifo[head]];
          r_start <= cur_time;
          r_end <= end_pop;
          r_fin <= 1'b0;
        end
        OP_REQUEUE: begin
          if (fill < CNT_W'(MAX_PROCS)) begin
            fifo[push_addr] <= idx;
            fill <= fill + 1'b1;
          end
        end
        OP_TAT: begin
          tat <= {4'd0, r_end} - {9'd0, arr_tab[idx]};
        end
        OP_ACCUM: begin
          r_fin <= 1'b1;
          finished <= finished + 1'b1;
          tat_total <= tat_total + tat;
          wait_total <= wait_total + (tat - {9'd0, bst_tab[idx]});
        end
        OP_EMIT: begin
          out_data.slice_valid <= r_valid;
          out_data.slice_proc <= r_proc;
          out_data.slice_start <= r_start;
          out_data.slice_end <= r_end;
          out_data.proc_finished <= r_fin;
          out_data.schedule_done <= (finished >= loaded);
          out_data.wait_sum <= wait_total;
          out_data.turnaround_sum <= tat_total;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: hdl/rrss_checker.sv
`timescale 1ns / 1ps
module rrss_checker
  import rrss_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input slice_out_t  out_data,
  input logic        cfg_valid,
  input logic        cfg_ready
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped under stall");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(out_data))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present after reset");

  a_no_instant: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> !$rose(out_valid))
    else $error("result appeared one cycle after transfer");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("config write refused");

endmodule

bind round_robin_slice_scheduler rrss_checker u_rrss_checker (.*);
